/* hdl/assert_macros.svh */
// Assertion macros shared by the euzyx RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the block clock, quiet during reset
`define EUZYX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication check, antecedent and consequent in the same cycle
`define EUZYX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication check, consequent in the next cycle
`define EUZYX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/euzyx_pkg.sv */
// Package for the Z-Y-X Euler vector rotator: widths, CORDIC constants, helpers.
// No dependencies.
`timescale 1ns / 1ps
package euzyx_pkg;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int VECTOR_BITS_DEF   = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  // internal word widths
  localparam int CX_W  = 34;  // CORDIC x/y in Q.30
  localparam int CZ_W  = 36;  // CORDIC residual angle in Q.30
  localparam int Q16_W = 20;  // sines, cosines and matrix entries in Q.16
  localparam int LANES = 3;   // roll, pitch, yaw

  localparam logic signed [CZ_W-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [CZ_W-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [CX_W-1:0] Q30_GAIN    = 34'sd652032874;

  typedef logic signed [Q16_W-1:0] q16_t;

  function automatic logic signed [CZ_W-1:0] step_angle(input int i);
    logic signed [CZ_W-1:0] a;
    case (i)
      0: a = 36'sd843314856;
      1: a = 36'sd497837829;
      2: a = 36'sd263043836;
      3: a = 36'sd133525158;
      4: a = 36'sd67021686;
      5: a = 36'sd33543515;
      6: a = 36'sd16775850;
      7: a = 36'sd8388437;
      8: a = 36'sd4194282;
      9: a = 36'sd2097149;
      default: a = (CZ_W'(1) <<< (30 - i)) - CZ_W'(1);
    endcase
    return a;
  endfunction

  // Q.16 product rounded half up
  function automatic q16_t mulq(input q16_t a, input q16_t b);
    logic signed [2*Q16_W-1:0] p;
    p = (2*Q16_W)'(a) * (2*Q16_W)'(b) + (2*Q16_W)'(32768);
    p = p >>> 16;
    return p[Q16_W-1:0];
  endfunction
endpackage

/* hdl/euzyx_in_if.sv */
// Input channel of the rotator: valid/ready plus angles, vector and direction.
// Default widths come from euzyx_pkg.
`timescale 1ns / 1ps
interface euzyx_in_if #(
  parameter int AB = euzyx_pkg::ANGLE_BITS_DEF,
  parameter int VB = euzyx_pkg::VECTOR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic signed [AB-1:0] roll_angle;
  logic signed [AB-1:0] pitch_angle;
  logic signed [AB-1:0] yaw_angle;
  logic signed [VB-1:0] vec_x;
  logic signed [VB-1:0] vec_y;
  logic signed [VB-1:0] vec_z;

  modport source (output valid, func, roll_angle, pitch_angle, yaw_angle,
                  vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, func, roll_angle, pitch_angle, yaw_angle,
                  vec_x, vec_y, vec_z, output ready);
endinterface

/* hdl/euzyx_out_if.sv */
// Result channel of the rotator: valid/ready plus rotated vector and clip flag.
// Default width comes from euzyx_pkg.
`timescale 1ns / 1ps
interface euzyx_out_if #(parameter int VB = euzyx_pkg::VECTOR_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic signed [VB-1:0] out_x;
  logic signed [VB-1:0] out_y;
  logic signed [VB-1:0] out_z;
  logic                 saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

/* hdl/euzyx_cordic.sv */
// Three-lane pipelined rotation-mode CORDIC: one register stage per iteration,
// plus a range-fold stage and a rounding stage. Uses euzyx_pkg.
`timescale 1ns / 1ps
module euzyx_cordic #(
  parameter int ANGLE_BITS    = euzyx_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = euzyx_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W        = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ANGLE_BITS-1:0] in_ang [euzyx_pkg::LANES],
  input  logic [SIDE_W-1:0]            in_side,
  output logic                         out_valid,
  input  logic                         out_ready,
  output euzyx_pkg::q16_t              out_sin [euzyx_pkg::LANES],
  output euzyx_pkg::q16_t              out_cos [euzyx_pkg::LANES],
  output logic [SIDE_W-1:0]            out_side
);
  localparam int P  = CORDIC_STAGES + 2;   // fold, iterations, round
  localparam int CX = euzyx_pkg::CX_W;
  localparam int CZ = euzyx_pkg::CZ_W;
  localparam int L  = euzyx_pkg::LANES;

  logic                 vld_r  [P];
  logic                 rdy    [P+1];
  logic [SIDE_W-1:0]    side_r [P];
  logic signed [CX-1:0] x_r    [P-1][L];
  logic signed [CX-1:0] y_r    [P-1][L];
  logic signed [CZ-1:0] z_r    [P-1][L];
  logic                 neg_r  [P-1][L];
  euzyx_pkg::q16_t      s_r    [L];
  euzyx_pkg::q16_t      c_r    [L];

  assign rdy[P] = out_ready;
  for (genvar p = 0; p < P; p++) begin : g_rdy
    assign rdy[p] = !vld_r[p] || rdy[p+1];
  end
  assign in_ready = rdy[0];

  for (genvar p = 0; p < P; p++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[p] <= 1'b0;
      end else if (rdy[p]) begin
        vld_r[p] <= (p == 0) ? in_valid : vld_r[(p == 0) ? 0 : p-1];
      end
    end
    always_ff @(posedge clk) begin
      if (rdy[p]) begin
        side_r[p] <= (p == 0) ? in_side : side_r[(p == 0) ? 0 : p-1];
      end
    end
  end

  for (genvar l = 0; l < L; l++) begin : g_lane
    logic signed [CZ-1:0] z_in;
    logic signed [CZ-1:0] z_fold_nxt;
    logic                 neg_nxt;

    assign z_in = CZ'(in_ang[l]) <<< (33 - ANGLE_BITS);

    // fold into +-pi/2, negate sine and cosine afterwards
    always_comb begin
      z_fold_nxt = z_in;
      neg_nxt    = 1'b0;
      if (z_in > euzyx_pkg::Q30_HALF_PI) begin
        z_fold_nxt = z_in - euzyx_pkg::Q30_PI;
        neg_nxt    = 1'b1;
      end else if (z_in < -euzyx_pkg::Q30_HALF_PI) begin
        z_fold_nxt = z_in + euzyx_pkg::Q30_PI;
        neg_nxt    = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[0]) begin
        x_r[0][l]   <= euzyx_pkg::Q30_GAIN;
        y_r[0][l]   <= '0;
        z_r[0][l]   <= z_fold_nxt;
        neg_r[0][l] <= neg_nxt;
      end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_it
      localparam logic signed [CZ-1:0] A = euzyx_pkg::step_angle(i);
      logic signed [CX-1:0] dx;
      logic signed [CX-1:0] dy;
      assign dx = y_r[i][l] >>> i;
      assign dy = x_r[i][l] >>> i;
      always_ff @(posedge clk) begin
        if (rdy[i+1]) begin
          neg_r[i+1][l] <= neg_r[i][l];
          if (z_r[i][l] >= 0) begin
            x_r[i+1][l] <= x_r[i][l] - dx;
            y_r[i+1][l] <= y_r[i][l] + dy;
            z_r[i+1][l] <= z_r[i][l] - A;
          end else begin
            x_r[i+1][l] <= x_r[i][l] + dx;
            y_r[i+1][l] <= y_r[i][l] - dy;
            z_r[i+1][l] <= z_r[i][l] + A;
          end
        end
      end
    end

    logic signed [CX-1:0] xr;
    logic signed [CX-1:0] yr;
    euzyx_pkg::q16_t      c_nxt;
    euzyx_pkg::q16_t      s_nxt;
    assign xr    = (x_r[P-2][l] + CX'(8192)) >>> 14;
    assign yr    = (y_r[P-2][l] + CX'(8192)) >>> 14;
    assign c_nxt = neg_r[P-2][l] ? -xr[euzyx_pkg::Q16_W-1:0] : xr[euzyx_pkg::Q16_W-1:0];
    assign s_nxt = neg_r[P-2][l] ? -yr[euzyx_pkg::Q16_W-1:0] : yr[euzyx_pkg::Q16_W-1:0];

    always_ff @(posedge clk) begin
      if (rdy[P-1]) begin
        c_r[l] <= c_nxt;
        s_r[l] <= s_nxt;
      end
    end
    assign out_sin[l] = s_r[l];
    assign out_cos[l] = c_r[l];
  end

  assign out_valid = vld_r[P-1];
  assign out_side  = side_r[P-1];
endmodule

/* hdl/euzyx_matrix.sv */
// Two-stage builder of the Z-Y-X rotation matrix from Q.16 sines and cosines.
// Uses euzyx_pkg (mulq).
`timescale 1ns / 1ps
module euzyx_matrix #(
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  euzyx_pkg::q16_t    in_sin [euzyx_pkg::LANES],
  input  euzyx_pkg::q16_t    in_cos [euzyx_pkg::LANES],
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_valid,
  input  logic               out_ready,
  output euzyx_pkg::q16_t    out_m [9],
  output logic [SIDE_W-1:0]  out_side
);
  logic va_r, vb_r, rdy_a, rdy_b;
  logic [SIDE_W-1:0] side_a_r, side_b_r;
  euzyx_pkg::q16_t sr_r, cr_r, sp_r, t_r, u_r;
  euzyx_pkg::q16_t cycp_r, sycr_r, sysr_r, sycp_r, cycr_r, cysr_r, cpsr_r, cpcr_r;
  euzyx_pkg::q16_t m_r [9];

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  // stage A: pair products (lane 0 roll, 1 pitch, 2 yaw)
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      side_a_r <= in_side;
      sr_r     <= in_sin[0];
      cr_r     <= in_cos[0];
      sp_r     <= in_sin[1];
      t_r      <= euzyx_pkg::mulq(in_cos[2], in_sin[1]);
      u_r      <= euzyx_pkg::mulq(in_sin[2], in_sin[1]);
      cycp_r   <= euzyx_pkg::mulq(in_cos[2], in_cos[1]);
      sycr_r   <= euzyx_pkg::mulq(in_sin[2], in_cos[0]);
      sysr_r   <= euzyx_pkg::mulq(in_sin[2], in_sin[0]);
      sycp_r   <= euzyx_pkg::mulq(in_sin[2], in_cos[1]);
      cycr_r   <= euzyx_pkg::mulq(in_cos[2], in_cos[0]);
      cysr_r   <= euzyx_pkg::mulq(in_cos[2], in_sin[0]);
      cpsr_r   <= euzyx_pkg::mulq(in_cos[1], in_sin[0]);
      cpcr_r   <= euzyx_pkg::mulq(in_cos[1], in_cos[0]);
    end
  end

  // stage B: triple products and entry sums
  always_ff @(posedge clk) begin
    if (rdy_b) begin
      side_b_r <= side_a_r;
      m_r[0]   <= cycp_r;
      m_r[1]   <= euzyx_pkg::mulq(t_r, sr_r) - sycr_r;
      m_r[2]   <= euzyx_pkg::mulq(t_r, cr_r) + sysr_r;
      m_r[3]   <= sycp_r;
      m_r[4]   <= euzyx_pkg::mulq(u_r, sr_r) + cycr_r;
      m_r[5]   <= euzyx_pkg::mulq(u_r, cr_r) - cysr_r;
      m_r[6]   <= -sp_r;
      m_r[7]   <= cpsr_r;
      m_r[8]   <= cpcr_r;
    end
  end

  assign out_valid = vb_r;
  assign out_side  = side_b_r;
  for (genvar k = 0; k < 9; k++) begin : g_out
    assign out_m[k] = m_r[k];
  end
endmodule

/* hdl/euzyx_mvmul.sv */
// Matrix-vector multiply (direct or transposed) with rounding and saturation.
// Two register stages; uses euzyx_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module euzyx_mvmul #(
  parameter int VECTOR_BITS = euzyx_pkg::VECTOR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  euzyx_pkg::q16_t               in_m [9],
  input  logic                          in_func,
  input  logic signed [VECTOR_BITS-1:0] in_vec [3],
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VECTOR_BITS-1:0] out_vec [3],
  output logic                          out_sat
);
  localparam int PW = euzyx_pkg::Q16_W + VECTOR_BITS;
  localparam int AW = PW + 2;
  localparam int OW = AW - 16;
  localparam logic signed [OW-1:0] HI = (OW'(1) <<< (VECTOR_BITS-1)) - OW'(1);
  localparam logic signed [OW-1:0] LO = -(OW'(1) <<< (VECTOR_BITS-1));

  logic vc_r, vd_r, rdy_c, rdy_d;
  logic signed [PW-1:0] prod_r [9];
  logic signed [VECTOR_BITS-1:0] o_r [3];
  logic sat_r;

  assign rdy_d    = !vd_r || out_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign in_ready = rdy_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_c) vc_r <= in_valid;
      if (rdy_d) vd_r <= vc_r;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar k = 0; k < 3; k++) begin : g_col
      euzyx_pkg::q16_t e;
      assign e = in_func ? in_m[k*3+r] : in_m[r*3+k];
      always_ff @(posedge clk) begin
        if (rdy_c) prod_r[r*3+k] <= PW'(e) * PW'(in_vec[k]);
      end
    end
  end

  logic signed [OW-1:0] o_nxt [3];
  logic [2:0]           clip;
  for (genvar r = 0; r < 3; r++) begin : g_sum
    logic signed [AW-1:0] acc;
    assign acc = AW'(prod_r[r*3]) + AW'(prod_r[r*3+1]) + AW'(prod_r[r*3+2])
               + AW'(32768);
    assign o_nxt[r] = OW'(acc >>> 16);
    assign clip[r]  = (o_nxt[r] > HI) || (o_nxt[r] < LO);
    always_ff @(posedge clk) begin
      if (rdy_d) begin
        if (o_nxt[r] > HI)      o_r[r] <= HI[VECTOR_BITS-1:0];
        else if (o_nxt[r] < LO) o_r[r] <= LO[VECTOR_BITS-1:0];
        else                    o_r[r] <= o_nxt[r][VECTOR_BITS-1:0];
      end
    end
    assign out_vec[r] = o_r[r];
  end

  always_ff @(posedge clk) begin
    if (rdy_d) sat_r <= |clip;
  end

  assign out_valid = vd_r;
  assign out_sat   = sat_r;

  logic at_limit;
  assign at_limit = (o_r[0] == HI[VECTOR_BITS-1:0]) || (o_r[0] == LO[VECTOR_BITS-1:0])
                 || (o_r[1] == HI[VECTOR_BITS-1:0]) || (o_r[1] == LO[VECTOR_BITS-1:0])
                 || (o_r[2] == HI[VECTOR_BITS-1:0]) || (o_r[2] == LO[VECTOR_BITS-1:0]);

  `EUZYX_ASSERT_IMP(a_sat_at_limit, vd_r && sat_r, at_limit, "saturated flag without a clip")
  `EUZYX_ASSERT_NEXT(a_hold_result, vd_r && !out_ready, vd_r, "result dropped while stalled")
endmodule

/* hdl/euler_zyx_vector_rotate.sv */
// Pipeline from input transaction to result: CORDIC fold, one stage per iteration and rounding,
// two matrix stages, two multiply stages.
// Throughput: one transaction per cycle; every stage holds in place under backpressure.
// Reset: synchronous active-low rst_n clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module euler_zyx_vector_rotate #(
  parameter int ANGLE_BITS    = euzyx_pkg::ANGLE_BITS_DEF,
  parameter int VECTOR_BITS   = euzyx_pkg::VECTOR_BITS_DEF,
  parameter int CORDIC_STAGES = euzyx_pkg::CORDIC_STAGES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  euzyx_in_if.sink   in_ch,
  euzyx_out_if.source out_ch
);
  localparam int SIDE_W = 1 + 3 * VECTOR_BITS;
  localparam int VB = VECTOR_BITS;

  logic signed [ANGLE_BITS-1:0] ang [euzyx_pkg::LANES];
  logic [SIDE_W-1:0] side_in, side_c, side_m;
  euzyx_pkg::q16_t sn [euzyx_pkg::LANES];
  euzyx_pkg::q16_t cs [euzyx_pkg::LANES];
  euzyx_pkg::q16_t mat [9];
  logic c_valid, c_ready, m_valid, m_ready;
  logic signed [VB-1:0] vec [3];
  logic signed [VB-1:0] res [3];

  assign ang[0]  = in_ch.roll_angle;
  assign ang[1]  = in_ch.pitch_angle;
  assign ang[2]  = in_ch.yaw_angle;
  assign side_in = {in_ch.func, in_ch.vec_x, in_ch.vec_y, in_ch.vec_z};

  euzyx_cordic #(
    .ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES), .SIDE_W(SIDE_W)
  ) u_cordic (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_ang(ang), .in_side(side_in),
    .out_valid(c_valid), .out_ready(c_ready), .out_sin(sn), .out_cos(cs),
    .out_side(side_c)
  );

  euzyx_matrix #(.SIDE_W(SIDE_W)) u_matrix (
    .clk, .rst_n,
    .in_valid(c_valid), .in_ready(c_ready), .in_sin(sn), .in_cos(cs), .in_side(side_c),
    .out_valid(m_valid), .out_ready(m_ready), .out_m(mat), .out_side(side_m)
  );

  assign vec[0] = side_m[3*VB-1:2*VB];
  assign vec[1] = side_m[2*VB-1:VB];
  assign vec[2] = side_m[VB-1:0];

  euzyx_mvmul #(.VECTOR_BITS(VECTOR_BITS)) u_mvmul (
    .clk, .rst_n,
    .in_valid(m_valid), .in_ready(m_ready), .in_m(mat), .in_func(side_m[SIDE_W-1]),
    .in_vec(vec),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_vec(res),
    .out_sat(out_ch.saturated)
  );

  assign out_ch.out_x = res[0];
  assign out_ch.out_y = res[1];
  assign out_ch.out_z = res[2];

  // an empty output stage frees the whole ready chain
  `EUZYX_ASSERT_IMP(a_empty_ready, !out_ch.valid, in_ch.ready, "input stalled with empty output")
endmodule

/* tb/euzyx_tb_if.sv */
// Testbench-side note: the channel interfaces come from the RTL (euzyx_in_if, euzyx_out_if).
// This file holds the rotation predictor package used by the checker; it has no dependencies.
`timescale 1ns / 1ps
package euzyx_tb_pkg;
  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               sat;
  } rot_result_t;

  function automatic longint floor_shift(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint arctan_step(input int i);
    longint tbl [10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                         33543515, 16775850, 8388437, 4194282, 2097149};
    if (i < 10) return tbl[i];
    return (longint'(1) << (30 - i)) - 1;
  endfunction

  function automatic longint q16_mul(input longint a, input longint b);
    return floor_shift(a * b + 32768, 16);
  endfunction

  task automatic cordic_sincos(input logic signed [15:0] ang, output longint s,
                               output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * (longint'(1) << 17);
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    x = floor_shift(x + 8192, 14);
    y = floor_shift(y + 8192, 14);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_rotation(input logic inv, input logic signed [15:0] roll,
                                  input logic signed [15:0] pitch,
                                  input logic signed [15:0] yaw,
                                  input logic signed [23:0] vx,
                                  input logic signed [23:0] vy,
                                  input logic signed [23:0] vz,
                                  output rot_result_t res);
    longint sr, cr, sp, cp, sy, cy, t, u, acc, o;
    longint m [3][3];
    longint v [3];
    longint comp [3];
    cordic_sincos(roll, sr, cr);
    cordic_sincos(pitch, sp, cp);
    cordic_sincos(yaw, sy, cy);
    v[0] = vx; v[1] = vy; v[2] = vz;
    t = q16_mul(cy, sp);
    u = q16_mul(sy, sp);
    m[0][0] = q16_mul(cy, cp);
    m[0][1] = q16_mul(t, sr) - q16_mul(sy, cr);
    m[0][2] = q16_mul(t, cr) + q16_mul(sy, sr);
    m[1][0] = q16_mul(sy, cp);
    m[1][1] = q16_mul(u, sr) + q16_mul(cy, cr);
    m[1][2] = q16_mul(u, cr) - q16_mul(cy, sr);
    m[2][0] = -sp;
    m[2][1] = q16_mul(cp, sr);
    m[2][2] = q16_mul(cp, cr);
    res.sat = 0;
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += (inv ? m[k][r] : m[r][k]) * v[k];
      o = floor_shift(acc + 32768, 16);
      if (o > 8388607) begin
        o = 8388607; res.sat = 1;
      end
      if (o < -8388608) begin
        o = -8388608; res.sat = 1;
      end
      comp[r] = o;
    end
    res.x = comp[0][23:0];
    res.y = comp[1][23:0];
    res.z = comp[2][23:0];
  endtask
endpackage

/* tb/rotate_checker.sv */
// Checker for the rotator: watches both channels, predicts each rotation and compares.
// Depends on euzyx_tb_pkg and the RTL channel interfaces.
`timescale 1ns / 1ps
module rotate_checker (
  input logic         clk,
  input logic         rst_n,
  euzyx_in_if.sink    in_mon,
  euzyx_out_if.sink   out_mon,
  output int          error_count,
  output int          pending_count
);
  euzyx_tb_pkg::rot_result_t rotated_q [$];

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    euzyx_tb_pkg::rot_result_t exp_r;
    if (rst_n && in_mon.valid && in_mon.ready) begin
      euzyx_tb_pkg::predict_rotation(in_mon.func, in_mon.roll_angle, in_mon.pitch_angle,
                                     in_mon.yaw_angle, in_mon.vec_x, in_mon.vec_y,
                                     in_mon.vec_z, exp_r);
      rotated_q = {rotated_q, exp_r};
    end
    if (rst_n && out_mon.valid && out_mon.ready) begin
      if (rotated_q.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        exp_r = rotated_q.pop_front();
        if (out_mon.out_x !== exp_r.x) report_mismatch("out_x", out_mon.out_x, exp_r.x);
        if (out_mon.out_y !== exp_r.y) report_mismatch("out_y", out_mon.out_y, exp_r.y);
        if (out_mon.out_z !== exp_r.z) report_mismatch("out_z", out_mon.out_z, exp_r.z);
        if (out_mon.saturated !== exp_r.sat)
          report_mismatch("saturated", out_mon.saturated, exp_r.sat);
      end
    end
    pending_count = rotated_q.size();
  end
endmodule

/* tb/tb_euler_zyx_vector_rotate.sv */
// Top of the rotator testbench: clock, reset, stimulus, result backpressure and verdict.
// Depends on euzyx_pkg, the RTL channel interfaces, euzyx_tb_pkg and rotate_checker.
`timescale 1ns / 1ps
module tb_euler_zyx_vector_rotate;
  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   idle_cycles;
  bit   tail_phase;
  bit   long_hold;

  euzyx_in_if  #(.AB(16), .VB(24)) in_ch ();
  euzyx_out_if #(.VB(24))          out_ch ();

  euler_zyx_vector_rotate dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  rotate_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                      .error_count(errors), .pending_count(pending));

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'sd25736;
      1: return -16'sd25736;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($signed($urandom_range(0, 51472)) - 25736);
    endcase
  endfunction

  function automatic logic signed [23:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($signed($urandom_range(0, 65535)) - 32768);
      default: return 24'($urandom);
    endcase
  endfunction

  // Offer one transaction and hold it until accepted.
  task automatic send_vector(input logic f, input logic signed [15:0] r,
                             input logic signed [15:0] p, input logic signed [15:0] y,
                             input logic signed [23:0] vx, input logic signed [23:0] vy,
                             input logic signed [23:0] vz);
    in_ch.valid       <= 1;
    in_ch.func        <= f;
    in_ch.roll_angle  <= r;
    in_ch.pitch_angle <= p;
    in_ch.yaw_angle   <= y;
    in_ch.vec_x       <= vx;
    in_ch.vec_y       <= vy;
    in_ch.vec_z       <= vz;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (!tail_phase && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  // Receiver: random stall bursts, one long hold, none in the tail.
  initial begin
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready <= 0;
        repeat (120) @(negedge clk);
        long_hold = 0;
      end
      if (!tail_phase && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic signed [15:0] edge_ang [5] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd32767,
                                         -16'sd32768};
    tail_phase = 0;
    long_hold  = 0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.func = 0;
    in_ch.roll_angle = 0;
    in_ch.pitch_angle = 0;
    in_ch.yaw_angle = 0;
    in_ch.vec_x = 0;
    in_ch.vec_y = 0;
    in_ch.vec_z = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: zero and extreme angles, both directions, extreme vectors.
    for (int i = 0; i < 5; i++) begin
      send_vector(i[0], edge_ang[i], edge_ang[4-i], edge_ang[(i+2)%5],
                  24'sh001000, -24'sh002000, 24'sh003000);
    end
    send_vector(0, 0, 0, 0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    send_vector(1, 0, 0, 0, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
    // Saturating: 45 deg rotations of full-scale vectors.
    send_vector(0, 16'sd6434, 16'sd6434, 16'sd6434, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_vector(1, -16'sd6434, -16'sd6434, 16'sd6434, 24'sh800000, 24'sh800000, 24'sh800000);
    // Near the pi/2 fold boundary.
    send_vector(0, 16'sd12868, -16'sd12868, 16'sd12869, 24'sh123456, -24'sh054321, 24'sh0ABCDE);
    send_vector(1, 16'sd12869, -16'sd12869, -16'sd12868, 24'sh123456, 24'sh054321, -24'sh0ABCDE);
    send_vector(0, 16'sd25736, 16'sd25736, 16'sd25736, -24'sd1, 24'sd1, 24'sd0);

    // Pause until every expected result has come.
    in_ch.valid <= 0;
    while (pending != 0) @(negedge clk);

    // Long receiver hold while the sender keeps offering.
    long_hold = 1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - 60) tail_phase = 1;
      if (!long_hold || n > 60) sender_gap();
      send_vector(1'($urandom_range(0, 1)), rand_angle(), rand_angle(), rand_angle(),
                  rand_comp(), rand_comp(), rand_comp());
    end
    in_ch.valid <= 0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hdl
hdl/euzyx_pkg.sv
hdl/euzyx_in_if.sv
hdl/euzyx_out_if.sv
hdl/euzyx_cordic.sv
hdl/euzyx_matrix.sv
hdl/euzyx_mvmul.sv
hdl/euler_zyx_vector_rotate.sv
tb/euzyx_tb_if.sv
tb/rotate_checker.sv
tb/tb_euler_zyx_vector_rotate.sv
